@@ hw/rtl/bounded_min_max_priority_queue_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bounded min/max priority queue
// Shared concurrent assertion forms, clocked on clk; the implication forms are gated by rst.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_MIN_MAX_PRIORITY_QUEUE_MACROS_SVH
`define BOUNDED_MIN_MAX_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, off while in reset
`define BMMPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("priority queue check failed");

// next-cycle implication, off while in reset
`define BMMPQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("priority queue check failed");

// condition that must hold in the cycle after reset is seen
`define BMMPQ_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("priority queue reset check failed");

`endif

@@ hw/rtl/bmmpq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmmpq_pkg
// Field widths, operation and status codes and shared types of the queue.
// ----------------------------------------------------------------------------
package bmmpq_pkg;

  localparam int MODE_W = 3;
  localparam int STAT_W = 3;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 8;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INS_VAL  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_PRI  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INFO     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TAKE_MIN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TAKE_MAX = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOINIT = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STAT_W-1:0] ST_ORDER  = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd4;

  // one stored pair
  typedef struct packed {
    logic [DATA_W-1:0] prio;
    logic [DATA_W-1:0] value;
  } entry_t;

  // outcome of the shared priority compare
  typedef struct packed {
    logic less;
    logic equal;
  } cmp_res_t;

endpackage

@@ hw/rtl/bmmpq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmmpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bmmpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/bmmpq_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmmpq_cmp
// Shared signed priority comparator used by every step of the position search.
// ----------------------------------------------------------------------------
module bmmpq_cmp (
  input  logic [bmmpq_pkg::DATA_W-1:0] stored,
  input  logic [bmmpq_pkg::DATA_W-1:0] probe,
  output bmmpq_pkg::cmp_res_t          res
);
  import bmmpq_pkg::*;

  // two's complement compare of stored against probe
  always_comb begin
    res.less  = $signed(stored) < $signed(probe);
    res.equal = (stored == probe);
  end

endmodule

@@ hw/rtl/bounded_min_max_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_min_max_priority_queue
// Double-ended priority queue of value/priority pairs sorted in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries mode and operand. An insert is
//   two beats: the value (mode 0), then its priority (mode 1). Mode 2 reports
//   count and capacity, modes 3 and 4 remove the lowest or highest priority.
//   Every input beat yields exactly one output beat (out_valid/out_ready).
//   cfg_write/cfg_data set the capacity; a write empties the queue and marks
//   it initialised. Write it only while the queue is idle.
//   Sequence: checks and info go straight to the last step; take max reads
//   the top entry and drops it. An insert runs a binary search, then moves
//   every entry above the new one up one place, each move one read and one
//   write on the single-read-port RAM. Take min moves every remaining entry
//   down. One item is worked on at a time; in_ready is high only while idle
//   and no capacity write is present, so a new beat is taken only once the
//   last one has left the sequencer. Entries live in a RAM with no reset: only
//   slots below the count are ever read. Reset clears count, the pending-value
//   flag and the initialised flag. A stalled receiver holds the output
//   register, and the sequencer waits at its last step until it is free.
// ----------------------------------------------------------------------------
module bounded_min_max_priority_queue #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bmmpq_pkg::MODE_W-1:0]        mode,
  input  logic signed [bmmpq_pkg::DATA_W-1:0] operand,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bmmpq_pkg::STAT_W-1:0]        status,
  output logic signed [bmmpq_pkg::DATA_W-1:0] result_value,
  output logic [bmmpq_pkg::CAP_W-1:0]         entry_count,
  output logic [bmmpq_pkg::CAP_W-1:0]         capacity_now,
  output logic                                duplicate_dropped,
  input  logic                                cfg_write,
  input  logic [bmmpq_pkg::CAP_W-1:0]         cfg_data
);
  import bmmpq_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int WW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_SR_ADDR = 10'b0000000010,
    S_SR_CMP  = 10'b0000000100,
    S_SH_RD   = 10'b0000001000,
    S_SH_WR   = 10'b0000010000,
    S_MN_CAP  = 10'b0000100000,
    S_MN_RD   = 10'b0001000000,
    S_MN_WR   = 10'b0010000000,
    S_MX_CAP  = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic                queue_ready;
  logic                value_pending;
  logic [DATA_W-1:0]   pending_value;
  logic [CAP_W-1:0]    queue_capacity;
  logic [DATA_W-1:0]   new_prio;
  logic [CW-1:0]       lo;
  logic [CW-1:0]       hi;
  logic [CW-1:0]       walk;
  logic [IW-1:0]       mid;
  logic [STAT_W-1:0]   op_status;
  logic [DATA_W-1:0]   op_result;
  logic                op_dup;

  logic                accept;
  logic                out_free;
  logic                full_now;
  logic [CW:0]         mid_sum;
  logic [CW-1:0]       mid_calc;
  logic [CW-1:0]       count_m1;
  logic [CW-1:0]       walk_m1;
  logic [WW-1:0]       count_wide;
  logic [STAT_W-1:0]   dec_status;
  state_t              dec_state;

  logic                ram_rd_en;
  logic [IW-1:0]       ram_rd_addr;
  logic                ram_wr_en;
  logic [IW-1:0]       ram_wr_addr;
  entry_t              ram_wr_data;
  entry_t              ram_rd_data;
  cmp_res_t            cmp_res;

  // entry store
  bmmpq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // shared priority compare
  bmmpq_cmp u_cmp (
    .stored (ram_rd_data.prio),
    .probe  (new_prio),
    .res    (cmp_res)
  );

  // handshake and helpers
  assign in_ready   = (state == S_IDLE) && !cfg_write;
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign count_wide = WW'(count);
  assign full_now   = (count_wide >= WW'(queue_capacity)) || (count >= MAX_CNT);
  assign mid_sum    = {1'b0, lo} + {1'b0, hi};
  assign mid_calc   = mid_sum[CW:1];
  assign count_m1   = count - 1'b1;
  assign walk_m1    = walk - 1'b1;

  // outcome and first step of an accepted beat
  always_comb begin
    dec_status = ST_OK;
    dec_state  = S_DONE;
    unique case (mode)
      MODE_INS_VAL: begin
        if (!queue_ready) begin
          dec_status = ST_NOINIT;
        end else if (full_now) begin
          dec_status = ST_FULL;
        end else if (value_pending) begin
          dec_status = ST_ORDER;
        end
      end
      MODE_INS_PRI: begin
        if (!queue_ready) begin
          dec_status = ST_NOINIT;
        end else if (!value_pending) begin
          dec_status = ST_ORDER;
        end else if (count >= MAX_CNT) begin
          dec_status = ST_FULL;
        end else begin
          dec_state = S_SR_ADDR;
        end
      end
      MODE_INFO: begin
        if (!queue_ready) begin
          dec_status = ST_NOINIT;
        end
      end
      MODE_TAKE_MIN: begin
        if (!queue_ready) begin
          dec_status = ST_NOINIT;
        end else if (count == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_state = S_MN_CAP;
        end
      end
      MODE_TAKE_MAX: begin
        if (!queue_ready) begin
          dec_status = ST_NOINIT;
        end else if (count == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_state = S_MX_CAP;
        end
      end
      default: begin
        dec_status = ST_ORDER;
      end
    endcase
  end

  // ram address and data selection
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = '0;
    ram_wr_data = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && queue_ready && (count != '0)) begin
          if (mode == MODE_TAKE_MIN) begin
            ram_rd_en = 1'b1;
          end else if (mode == MODE_TAKE_MAX) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = count_m1[IW-1:0];
          end
        end
      end
      S_SR_ADDR: begin
        if (lo != hi) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = mid_calc[IW-1:0];
        end
      end
      S_SH_RD: begin
        if (walk > lo) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = walk_m1[IW-1:0];
        end else begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = lo[IW-1:0];
          ram_wr_data = '{prio: new_prio, value: pending_value};
        end
      end
      S_SH_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = walk[IW-1:0];
        ram_wr_data = ram_rd_data;
      end
      S_MN_RD: begin
        if (walk < count) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = walk[IW-1:0];
        end
      end
      S_MN_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = walk_m1[IW-1:0];
        ram_wr_data = ram_rd_data;
      end
      default: begin
      end
    endcase
  end

  // sequencer, queue state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      count          <= '0;
      queue_ready    <= 1'b0;
      value_pending  <= 1'b0;
      queue_capacity <= '0;
      out_valid      <= 1'b0;
    end else begin
      // output beat loaded at the last step, dropped once taken
      if ((state == S_DONE) && out_free && !cfg_write) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_write) begin
        // capacity write empties the queue
        queue_capacity <= cfg_data;
        count          <= '0;
        value_pending  <= 1'b0;
        queue_ready    <= 1'b1;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (accept) begin
              op_status <= dec_status;
              op_result <= '0;
              op_dup    <= 1'b0;
              new_prio  <= operand;
              lo        <= '0;
              hi        <= count;
              state     <= dec_state;
              // two-step insert bookkeeping
              if ((mode == MODE_INS_VAL) && (dec_status == ST_OK)) begin
                value_pending <= 1'b1;
                pending_value <= operand;
              end else if ((mode == MODE_INS_PRI) && queue_ready) begin
                value_pending <= 1'b0;
              end
            end
          end
          // binary search for the first stored priority not below the new one
          S_SR_ADDR: begin
            if (lo == hi) begin
              walk  <= count;
              state <= S_SH_RD;
            end else begin
              mid   <= mid_calc[IW-1:0];
              state <= S_SR_CMP;
            end
          end
          S_SR_CMP: begin
            if (cmp_res.equal) begin
              op_dup <= 1'b1;
              state  <= S_DONE;
            end else begin
              if (cmp_res.less) begin
                lo <= CW'(mid) + 1'b1;
              end else begin
                hi <= CW'(mid);
              end
              state <= S_SR_ADDR;
            end
          end
          // open a slot by moving the upper entries up one place
          S_SH_RD: begin
            if (walk > lo) begin
              state <= S_SH_WR;
            end else begin
              count <= count + 1'b1;
              state <= S_DONE;
            end
          end
          S_SH_WR: begin
            walk  <= walk_m1;
            state <= S_SH_RD;
          end
          // take min: capture bottom entry, then move the rest down
          S_MN_CAP: begin
            op_result <= ram_rd_data.value;
            walk      <= CW'(1);
            state     <= S_MN_RD;
          end
          S_MN_RD: begin
            if (walk < count) begin
              state <= S_MN_WR;
            end else begin
              count <= count_m1;
              state <= S_DONE;
            end
          end
          S_MN_WR: begin
            walk  <= walk + 1'b1;
            state <= S_MN_RD;
          end
          // take max: top entry drops off
          S_MX_CAP: begin
            op_result <= ram_rd_data.value;
            count     <= count_m1;
            state     <= S_DONE;
          end
          // load the output register once it is free
          S_DONE: begin
            if (out_free) begin
              status            <= op_status;
              result_value      <= op_result;
              entry_count       <= count_wide[CAP_W-1:0];
              capacity_now      <= queue_capacity;
              duplicate_dropped <= op_dup;
              state             <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

@@ hw/rtl/bmmpq_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmmpq_chk
// Port-level checks on the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_min_max_priority_queue_macros.svh"

module bmmpq_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [bmmpq_pkg::STAT_W-1:0]        status,
  input logic signed [bmmpq_pkg::DATA_W-1:0] result_value,
  input logic [bmmpq_pkg::CAP_W-1:0]         entry_count,
  input logic                                duplicate_dropped
);
  import bmmpq_pkg::*;

  // no result beat right after reset
  `BMMPQ_ASSERT_RST(a_rst_no_beat, !out_valid)

  // a stalled result beat stays put
  `BMMPQ_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(result_value))

  // only a successful take returns a value
  `BMMPQ_ASSERT_IMP(a_fail_zero, out_valid && (status != ST_OK), result_value == 0)

  // empty or uninitialised answers come with no stored entries
  `BMMPQ_ASSERT_IMP(a_empty_count, out_valid && ((status == ST_EMPTY) || (status == ST_NOINIT)), entry_count == 0)

  // a dropped duplicate is still a successful insert
  `BMMPQ_ASSERT_IMP(a_dup_ok, out_valid && duplicate_dropped, status == ST_OK)

endmodule

bind bounded_min_max_priority_queue bmmpq_chk u_chk (.*);
